/* hdl/ras_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ras_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_ROW0     = 4'd0,
    CFG_ROT_ROW1     = 4'd1,
    CFG_ROT_ROW2     = 4'd2,
    CFG_POSITION_XY  = 4'd3,
    CFG_POSITION_Z   = 4'd4,
    CFG_OUTER_RADIUS = 4'd5,
    CFG_INNER_RADIUS = 4'd6,
    CFG_SECTOR_ANGLE = 4'd7
  } cfg_reg_e;

  localparam logic [47:0] ROT_ROW0_RST = 48'd16384;
  localparam logic [47:0] ROT_ROW1_RST = 48'd16384 << 16;
  localparam logic [47:0] ROT_ROW2_RST = 48'd16384 << 32;
  localparam logic [30:0] OUTER_RST    = 31'd65536;
  localparam logic [16:0] SECTOR_RST   = 17'd65536;
  localparam logic [16:0] ONE_Q16      = 17'd65536;

  // Angle constants in 1/65536 turn, accumulator in 1/2^20 turn
  localparam logic signed [23:0] HALF_TURN_ACC = 24'sd524288;
  localparam int QUARTER = 16384;
  localparam int HALF    = 32768;
  localparam int THREE_Q = 49152;
  localparam int FULL    = 65536;

  localparam int DIV_STEPS    = 48;
  localparam int LOOP_STEPS   = 32;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_FIRST = NORM_STEPS + 1;
  localparam int CORDIC_STEPS = 18;
  localparam int FRAC_STEPS   = 17;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
  } ras_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_hit;
    logic [16:0]        u_coord;
    logic [16:0]        v_coord;
  } ras_out_t;

  function automatic logic signed [23:0] atan_step(input int i);
    logic signed [23:0] a;
    unique case (i)
      0:  a = 24'sd131072;
      1:  a = 24'sd77376;
      2:  a = 24'sd40884;
      3:  a = 24'sd20753;
      4:  a = 24'sd10417;
      5:  a = 24'sd5213;
      6:  a = 24'sd2607;
      7:  a = 24'sd1304;
      8:  a = 24'sd652;
      9:  a = 24'sd326;
      10: a = 24'sd163;
      11: a = 24'sd81;
      12: a = 24'sd41;
      13: a = 24'sd20;
      14: a = 24'sd10;
      15: a = 24'sd5;
      16: a = 24'sd3;
      17: a = 24'sd1;
      default: a = 24'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* hdl/ray_annulus_sector_intersect.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
// in        in         in_valid_i/in_stall_o   in_data_i (ras_in_t)
// out       out        out_valid_o/out_stall_i out_data_o (ras_out_t)
//
// One request per cycle while the output is not stalled.
// The 48-step divider for t and the 32-step shared square-root / CORDIC
// section both run one step per register stage.
// Reset clears all valid bits and loads the identity transform.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.

module ray_annulus_sector_intersect (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [ras_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ras_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire ras_pkg::ras_in_t               in_data_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      ras_pkg::ras_out_t              out_data_o
);

  typedef struct packed {
    logic [33:0]        rem;
    logic [47:0]        nq;
    logic [31:0]        den;
    logic               neg;
    logic               miss;
    logic signed [31:0] lox;
    logic signed [31:0] loy;
    logic signed [31:0] ldx;
    logic signed [31:0] ldy;
    logic signed [31:0] tn;
    logic signed [31:0] tf;
  } div_t;

  typedef struct packed {
    logic signed [43:0] cx;
    logic signed [43:0] cy;
    logic [40:0]        m;
    logic signed [23:0] acc;
    logic [62:0]        n;
    logic [63:0]        res;
    logic               xneg;
    logic               yneg;
    logic               xzero;
    logic               yzero;
    logic               miss;
    logic signed [31:0] t;
  } ang_t;

  typedef struct packed {
    logic [32:0]        urem;
    logic [16:0]        unq;
    logic [31:0]        ud;
    logic [32:0]        vrem;
    logic [16:0]        vnq;
    logic [31:0]        vd;
    logic               uzero;
    logic               vzero;
    logic               miss;
    logic signed [31:0] t;
  } frac_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [47:0]        rot0_q, rot1_q, rot2_q;
  logic [63:0]        pos_xy_q;
  logic signed [31:0] pos_z_q;
  logic [30:0]        outer_q, inner_q;
  logic [16:0]        sector_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot0_q   <= ras_pkg::ROT_ROW0_RST;
      rot1_q   <= ras_pkg::ROT_ROW1_RST;
      rot2_q   <= ras_pkg::ROT_ROW2_RST;
      pos_xy_q <= '0;
      pos_z_q  <= '0;
      outer_q  <= ras_pkg::OUTER_RST;
      inner_q  <= '0;
      sector_q <= ras_pkg::SECTOR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ras_pkg::CFG_ROT_ROW0:     rot0_q   <= cfg_data_i[47:0];
        ras_pkg::CFG_ROT_ROW1:     rot1_q   <= cfg_data_i[47:0];
        ras_pkg::CFG_ROT_ROW2:     rot2_q   <= cfg_data_i[47:0];
        ras_pkg::CFG_POSITION_XY:  pos_xy_q <= cfg_data_i;
        ras_pkg::CFG_POSITION_Z:   pos_z_q  <= signed'(cfg_data_i[31:0]);
        ras_pkg::CFG_OUTER_RADIUS: outer_q  <= cfg_data_i[30:0];
        ras_pkg::CFG_INNER_RADIUS: inner_q  <= cfg_data_i[30:0];
        ras_pkg::CFG_SECTOR_ANGLE: sector_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  logic [47:0] rot [3];
  assign rot[0] = rot0_q;
  assign rot[1] = rot1_q;
  assign rot[2] = rot2_q;

  // ---------------------------------------------------------------------------
  // Global advance: hold everything while the output is stalled
  logic adv;
  logic out_valid_q;
  ras_pkg::ras_out_t out_data_q;

  assign adv         = ~(out_valid_q & out_stall_i);
  assign in_stall_o  = ~adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Functions
  function automatic logic signed [31:0] sat_xform(input logic signed [50:0] s);
    logic signed [36:0] sh;
    sh = 37'(s >>> 14);
    if (sh > 37'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (sh < -37'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(sh);
  endfunction

  function automatic div_t div_step(input div_t a);
    div_t       b;
    logic [33:0] r2;
    logic        ge;
    b  = a;
    r2 = {a.rem[32:0], a.nq[47]};
    ge = r2 >= {2'b00, a.den};
    b.rem = ge ? r2 - {2'b00, a.den} : r2;
    b.nq  = {a.nq[46:0], ge};
    return b;
  endfunction

  function automatic ang_t sqrt_step(input ang_t a, input int j);
    ang_t        b;
    logic [63:0] bt;
    logic [63:0] tr;
    b  = a;
    bt = 64'd1 << (62 - 2 * j);
    tr = a.res + bt;
    if ({1'b0, a.n} >= tr) begin
      b.n   = 63'({1'b0, a.n} - tr);
      b.res = (a.res >> 1) + bt;
    end else begin
      b.res = a.res >> 1;
    end
    return b;
  endfunction

  function automatic ang_t norm_step(input ang_t a, input int k);
    ang_t b;
    b = a;
    if (a.m < (41'd1 << (41 - k))) begin
      b.cx = a.cx <<< k;
      b.cy = a.cy <<< k;
      b.m  = a.m << k;
    end
    return b;
  endfunction

  function automatic ang_t pre_rotate(input ang_t a);
    ang_t b;
    b = a;
    if (a.cx < 0) begin
      b.cx  = -a.cx;
      b.cy  = -a.cy;
      b.acc = ras_pkg::HALF_TURN_ACC;
    end
    return b;
  endfunction

  function automatic ang_t cordic_step(input ang_t a, input int i);
    ang_t               b;
    logic signed [43:0] dxs;
    logic signed [43:0] dys;
    b   = a;
    dxs = a.cx >>> i;
    dys = a.cy >>> i;
    if (a.cy > 0) begin
      b.cx  = a.cx + dys;
      b.cy  = a.cy - dxs;
      b.acc = a.acc + ras_pkg::atan_step(i);
    end else begin
      b.cx  = a.cx - dys;
      b.cy  = a.cy + dxs;
      b.acc = a.acc - ras_pkg::atan_step(i);
    end
    return b;
  endfunction

  function automatic logic signed [23:0] clamp24(input logic signed [23:0] x,
                                                 input int lo, input int hi);
    if (x < 24'(lo)) begin
      return 24'(lo);
    end else if (x > 24'(hi)) begin
      return 24'(hi);
    end
    return x;
  endfunction

  function automatic logic [49:0] frac_step(input logic [32:0] rem,
                                            input logic [16:0] nq,
                                            input logic [31:0] d);
    logic [32:0] r2;
    logic        ge;
    logic [32:0] rn;
    r2 = {rem[31:0], nq[16]};
    ge = r2 >= {1'b0, d};
    rn = ge ? r2 - {1'b0, d} : r2;
    return {rn, nq[15:0], ge};
  endfunction

  // ---------------------------------------------------------------------------
  // Stage 1: register request, subtract disk position
  logic                s1_v_q;
  logic signed [32:0]  s1_o_q [3];
  logic signed [31:0]  s1_d_q [3];
  logic signed [31:0]  s1_tn_q, s1_tf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_o_q[0] <= 33'(in_data_i.origin_x) - 33'(signed'(pos_xy_q[31:0]));
      s1_o_q[1] <= 33'(in_data_i.origin_y) - 33'(signed'(pos_xy_q[63:32]));
      s1_o_q[2] <= 33'(in_data_i.origin_z) - 33'(pos_z_q);
      s1_d_q[0] <= in_data_i.dir_x;
      s1_d_q[1] <= in_data_i.dir_y;
      s1_d_q[2] <= in_data_i.dir_z;
      s1_tn_q   <= in_data_i.t_near;
      s1_tf_q   <= in_data_i.t_far;
    end
  end

  // Stage 2: rotation products
  logic               s2_v_q;
  logic signed [48:0] s2_po_q [3][3];
  logic signed [48:0] s2_pd_q [3][3];
  logic signed [31:0] s2_tn_q, s2_tf_q;
  logic signed [48:0] s2_po_d [3][3];
  logic signed [48:0] s2_pd_d [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s2_po_d[r][c] = 49'(signed'(rot[r][16*c +: 16])) * 49'(s1_o_q[c]);
        s2_pd_d[r][c] = 49'(signed'(rot[r][16*c +: 16])) * 49'(s1_d_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_po_q <= s2_po_d;
      s2_pd_q <= s2_pd_d;
      s2_tn_q <= s1_tn_q;
      s2_tf_q <= s1_tf_q;
    end
  end

  // Stage 3: row sums, scale and saturate
  logic               s3_v_q;
  logic signed [31:0] s3_lo_q [3];
  logic signed [31:0] s3_ld_q [3];
  logic signed [31:0] s3_tn_q, s3_tf_q;
  logic signed [31:0] s3_lo_d [3];
  logic signed [31:0] s3_ld_d [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s3_lo_d[r] = sat_xform(51'(s2_po_q[r][0]) + 51'(s2_po_q[r][1]) + 51'(s2_po_q[r][2]));
      s3_ld_d[r] = sat_xform(51'(s2_pd_q[r][0]) + 51'(s2_pd_q[r][1]) + 51'(s2_pd_q[r][2]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_lo_q <= s3_lo_d;
      s3_ld_q <= s3_ld_d;
      s3_tn_q <= s2_tn_q;
      s3_tf_q <= s2_tf_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider for t = -loz * 2^16 / ldz, one quotient bit per stage
  logic div_v_q [ras_pkg::DIV_STEPS+1];
  div_t div_q   [ras_pkg::DIV_STEPS+1];
  div_t div_set;

  always_comb begin
    div_set      = '0;
    div_set.nq   = {(s3_lo_q[2][31] ? 32'(-s3_lo_q[2]) : 32'(s3_lo_q[2])), 16'd0};
    div_set.den  = s3_ld_q[2][31] ? 32'(-s3_ld_q[2]) : 32'(s3_ld_q[2]);
    div_set.neg  = (s3_lo_q[2] > 0) ^ s3_ld_q[2][31];
    div_set.miss = (s3_ld_q[2] == 0);
    div_set.lox  = s3_lo_q[0];
    div_set.loy  = s3_lo_q[1];
    div_set.ldx  = s3_ld_q[0];
    div_set.ldy  = s3_ld_q[1];
    div_set.tn   = s3_tn_q;
    div_set.tf   = s3_tf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q[0] <= 1'b0;
    end else if (adv) begin
      div_v_q[0] <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= div_set;
    end
  end

  for (genvar k = 0; k < ras_pkg::DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        div_v_q[k+1] <= div_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k+1] <= div_step(div_q[k]);
      end
    end
  end

  // Stage 4: sign of t, interval check
  div_t               dv_o;
  logic signed [48:0] tq;
  logic signed [48:0] t49;
  logic               s4_v_q, s4_miss_q;
  logic signed [31:0] s4_t_q, s4_lox_q, s4_loy_q, s4_ldx_q, s4_ldy_q;

  assign dv_o = div_q[ras_pkg::DIV_STEPS];
  assign tq   = signed'({1'b0, dv_o.nq});
  assign t49  = dv_o.neg ? -tq : tq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (adv) begin
      s4_v_q <= div_v_q[ras_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_miss_q <= dv_o.miss || (t49 < 49'(dv_o.tn)) || (t49 > 49'(dv_o.tf));
      s4_t_q    <= 32'(t49);
      s4_lox_q  <= dv_o.lox;
      s4_loy_q  <= dv_o.loy;
      s4_ldx_q  <= dv_o.ldx;
      s4_ldy_q  <= dv_o.ldy;
    end
  end

  // Stage 5: t * direction
  logic               s5_v_q, s5_miss_q;
  logic signed [63:0] s5_px_q, s5_py_q;
  logic signed [31:0] s5_t_q, s5_lox_q, s5_loy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (adv) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_px_q   <= 64'(s4_t_q) * 64'(s4_ldx_q);
      s5_py_q   <= 64'(s4_t_q) * 64'(s4_ldy_q);
      s5_t_q    <= s4_t_q;
      s5_lox_q  <= s4_lox_q;
      s5_loy_q  <= s4_loy_q;
      s5_miss_q <= s4_miss_q;
    end
  end

  // Stage 6: hit point, box check against the outer radius
  logic signed [48:0] hx49, hy49, ob49;
  logic               s6_v_q, s6_miss_q;
  logic signed [31:0] s6_hx_q, s6_hy_q, s6_t_q;

  assign hx49 = 49'(s5_lox_q) + 49'(signed'(s5_px_q[63:16]));
  assign hy49 = 49'(s5_loy_q) + 49'(signed'(s5_py_q[63:16]));
  assign ob49 = signed'({18'd0, outer_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (adv) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_miss_q <= s5_miss_q || (hx49 > ob49) || (hx49 < -ob49) ||
                   (hy49 > ob49) || (hy49 < -ob49);
      s6_hx_q   <= 32'(hx49);
      s6_hy_q   <= 32'(hy49);
      s6_t_q    <= s5_t_q;
    end
  end

  // Stage 7: squares
  logic               s7_v_q, s7_miss_q;
  logic [63:0]        s7_hxs_q, s7_hys_q;
  logic [61:0]        s7_ins_q, s7_outs_q;
  logic signed [31:0] s7_hx_q, s7_hy_q, s7_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else if (adv) begin
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_hxs_q  <= 64'(64'(s6_hx_q) * 64'(s6_hx_q));
      s7_hys_q  <= 64'(64'(s6_hy_q) * 64'(s6_hy_q));
      s7_ins_q  <= 62'(inner_q) * 62'(inner_q);
      s7_outs_q <= 62'(outer_q) * 62'(outer_q);
      s7_hx_q   <= s6_hx_q;
      s7_hy_q   <= s6_hy_q;
      s7_t_q    <= s6_t_q;
      s7_miss_q <= s6_miss_q;
    end
  end

  // Stage 8: squared radius against the annulus bounds
  logic [63:0]        d2;
  logic               s8_v_q, s8_miss_q;
  logic [62:0]        s8_d2_q;
  logic signed [31:0] s8_hx_q, s8_hy_q, s8_t_q;

  assign d2 = s7_hxs_q + s7_hys_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else if (adv) begin
      s8_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_miss_q <= s7_miss_q || (d2 < 64'(s7_ins_q)) || (d2 > 64'(s7_outs_q));
      s8_d2_q   <= 63'(d2);
      s8_hx_q   <= s7_hx_q;
      s8_hy_q   <= s7_hy_q;
      s8_t_q    <= s7_t_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared section: square root every stage, alongside normalize,
  // half-turn pre-rotation and CORDIC vectoring
  logic        ang_v_q [ras_pkg::LOOP_STEPS+1];
  ang_t        ang_q   [ras_pkg::LOOP_STEPS+1];
  ang_t        ang_set;
  logic [31:0] ax, ay;

  assign ax = s8_hx_q[31] ? 32'(-s8_hx_q) : 32'(s8_hx_q);
  assign ay = s8_hy_q[31] ? 32'(-s8_hy_q) : 32'(s8_hy_q);

  always_comb begin
    ang_set       = '0;
    ang_set.cx    = 44'(s8_hx_q);
    ang_set.cy    = 44'(s8_hy_q);
    ang_set.m     = 41'((ax > ay) ? ax : ay);
    ang_set.n     = s8_d2_q;
    ang_set.xneg  = s8_hx_q[31];
    ang_set.yneg  = s8_hy_q[31];
    ang_set.xzero = (s8_hx_q == 0);
    ang_set.yzero = (s8_hy_q == 0);
    ang_set.miss  = s8_miss_q;
    ang_set.t     = s8_t_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_v_q[0] <= 1'b0;
    end else if (adv) begin
      ang_v_q[0] <= s8_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang_q[0] <= ang_set;
    end
  end

  for (genvar j = 0; j < ras_pkg::LOOP_STEPS; j++) begin : g_ang
    ang_t nx;

    always_comb begin
      nx = sqrt_step(ang_q[j], j);
      if (j < ras_pkg::NORM_STEPS) begin
        nx = norm_step(nx, 32 >> j);
      end else if (j == ras_pkg::NORM_STEPS) begin
        nx = pre_rotate(nx);
      end else if (j < ras_pkg::CORDIC_FIRST + ras_pkg::CORDIC_STEPS) begin
        nx = cordic_step(nx, j - ras_pkg::CORDIC_FIRST);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ang_v_q[j+1] <= 1'b0;
      end else if (adv) begin
        ang_v_q[j+1] <= ang_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ang_q[j+1] <= nx;
      end
    end
  end

  // Angle wrap-up and setup of the u and v dividers
  ang_t               ag;
  logic signed [23:0] p_rnd;
  logic signed [23:0] phi_s;
  logic [16:0]        phi;
  logic [31:0]        r_int;
  logic               vzero;
  frac_t              frac_set;

  assign ag    = ang_q[ras_pkg::LOOP_STEPS];
  assign p_rnd = (ag.acc + 24'sd8) >>> 4;
  assign r_int = ag.res[31:0];

  always_comb begin
    priority if (ag.yzero) begin
      phi_s = ag.xneg ? 24'(ras_pkg::HALF) : 24'sd0;
    end else if (ag.xzero) begin
      phi_s = ag.yneg ? 24'(ras_pkg::THREE_Q) : 24'(ras_pkg::QUARTER);
    end else if (!ag.xneg && !ag.yneg) begin
      phi_s = clamp24(p_rnd, 0, ras_pkg::QUARTER);
    end else if (ag.xneg && !ag.yneg) begin
      phi_s = clamp24(p_rnd, ras_pkg::QUARTER, ras_pkg::HALF);
    end else if (ag.xneg) begin
      phi_s = clamp24(p_rnd, ras_pkg::HALF, ras_pkg::THREE_Q);
    end else begin
      phi_s = clamp24(p_rnd, -ras_pkg::QUARTER, -1) + 24'(ras_pkg::FULL);
    end
  end

  assign phi   = 17'(phi_s);
  assign vzero = !(outer_q > inner_q) || !(r_int > {1'b0, inner_q});

  always_comb begin
    frac_set       = '0;
    frac_set.urem  = 33'(phi[16:1]);
    frac_set.unq   = {phi[0], 16'd0};
    frac_set.ud    = 32'(sector_q);
    frac_set.uzero = (sector_q == 0);
    frac_set.vzero = vzero;
    if (vzero) begin
      frac_set.vd = 32'd1;
    end else begin
      frac_set.vrem = 33'(r_int[31:1] - {1'b0, inner_q[30:1]} -
                          31'(~r_int[0] & inner_q[0]));
      frac_set.vnq  = {r_int[0] ^ inner_q[0], 16'd0};
      frac_set.vd   = 32'(outer_q - inner_q);
    end
    frac_set.miss = ag.miss || (phi > sector_q);
    frac_set.t    = ag.t;
  end

  // ---------------------------------------------------------------------------
  // Fraction dividers for u and v, one quotient bit per stage
  logic  frac_v_q [ras_pkg::FRAC_STEPS+1];
  frac_t frac_q   [ras_pkg::FRAC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_v_q[0] <= 1'b0;
    end else if (adv) begin
      frac_v_q[0] <= ang_v_q[ras_pkg::LOOP_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      frac_q[0] <= frac_set;
    end
  end

  for (genvar k = 0; k < ras_pkg::FRAC_STEPS; k++) begin : g_frac
    frac_t fx;

    always_comb begin
      fx = frac_q[k];
      {fx.urem, fx.unq} = frac_step(frac_q[k].urem, frac_q[k].unq, frac_q[k].ud);
      {fx.vrem, fx.vnq} = frac_step(frac_q[k].vrem, frac_q[k].vnq, frac_q[k].vd);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        frac_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        frac_v_q[k+1] <= frac_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        frac_q[k+1] <= fx;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  frac_t             fo;
  ras_pkg::ras_out_t out_d;

  assign fo = frac_q[ras_pkg::FRAC_STEPS];

  always_comb begin
    out_d = '0;
    if (!fo.miss) begin
      out_d.hit     = 1'b1;
      out_d.t_hit   = fo.t;
      out_d.u_coord = fo.uzero ? 17'd0 :
                      (fo.unq > ras_pkg::ONE_Q16) ? ras_pkg::ONE_Q16 : fo.unq;
      out_d.v_coord = fo.vzero ? 17'd0 :
                      (fo.vnq > ras_pkg::ONE_Q16) ? ras_pkg::ONE_Q16 : fo.vnq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= frac_v_q[ras_pkg::FRAC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_d;
    end
  end

endmodule

`default_nettype wire
